// ===== src/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the seven-segment thermometer
// Reading limit, temperature offsets, digit patterns and the stage payload.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int unsigned READING_W = 16;
	localparam int unsigned MAG_W     = 11;  // magnitude up to 1220 for readings within the limit
	localparam int unsigned WORD_W    = 30;
	localparam int unsigned DIGIT_W   = 7;

	localparam logic [READING_W-1:0] READING_LIMIT = 16'd64000;
	localparam logic [11:0]          C_OFFSET      = 12'd500;
	localparam logic [MAG_W-1:0]     F_OFFSET      = 11'd320;

	localparam logic [DIGIT_W-1:0] MINUS_PAT = 7'h01;
	localparam int unsigned        CELSIUS_BIT    = 28;
	localparam int unsigned        FAHRENHEIT_BIT = 29;

	// reciprocals: x*RECIP5 >> 18 = x/5, x*RECIP10 >> 19 = x/10, x*RECIP10_S >> 11 = x/10
	localparam logic [15:0] RECIP5    = 16'd52429;
	localparam logic [15:0] RECIP10   = 16'd52429;
	localparam logic [7:0]  RECIP10_S = 8'd205;

	typedef struct packed {
		logic             err;
		logic             fahr;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} conv_t;

	function automatic logic [DIGIT_W-1:0] seg_digit(input logic [3:0] d);
		logic [DIGIT_W-1:0] p;
		unique case (d)
			4'd0: p = 7'h7E;
			4'd1: p = 7'h0C;
			4'd2: p = 7'h37;
			4'd3: p = 7'h1F;
			4'd4: p = 7'h4D;
			4'd5: p = 7'h5B;
			4'd6: p = 7'h7B;
			4'd7: p = 7'h0E;
			4'd8: p = 7'h7F;
			4'd9: p = 7'h5F;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

// ===== src/sst_convert.sv =====
// ----------------------------------------------------------------------------
// sst_convert: reading to signed temperature
// Three stages: range check and Celsius scaling, magnitude and x9,
// divide by five and Fahrenheit offset, giving sign and magnitude.
// ----------------------------------------------------------------------------
module sst_convert (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fahr,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sst_pkg::READING_W-1:0] reading,
	output logic                         out_valid,
	input  logic                         out_ready,
	output sst_pkg::conv_t               out_data
);
	import sst_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic               err_s1, fahr_s1;
	logic signed [11:0] t_s1;
	logic               err_s2, fahr_s2, neg_s2;
	logic [12:0]        val_s2;
	logic               err_s3, fahr_s3, neg_s3;
	logic [MAG_W-1:0]   mag_s3;

	logic [16:0]        sum1;
	logic signed [11:0] t1;
	logic [11:0]        abs2;
	logic [12:0]        val2;
	logic [28:0]        prod3;
	logic [9:0]         quo3;
	logic [MAG_W-1:0]   mag3;
	logic               neg3;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// stage 1: tenths of a degree Celsius
	always_comb begin
		sum1 = {1'b0, reading} + 17'd32;
		t1   = $signed({1'b0, sum1[16:6]}) - $signed(C_OFFSET);
	end

	// stage 2: magnitude, scaled by nine in Fahrenheit mode
	always_comb begin
		abs2 = t_s1[11] ? 12'(-t_s1) : 12'(t_s1);
		if (fahr_s1) begin
			val2 = 13'(abs2[9:0]) * 13'd9;
		end else begin
			val2 = 13'(abs2[9:0]);
		end
	end

	// stage 3: in Fahrenheit mode divide by five toward zero, then add the offset to the signed value
	always_comb begin
		prod3 = 29'(val_s2) * 29'(RECIP5);
		quo3  = prod3[27:18];
		if (!fahr_s2) begin
			mag3 = val_s2[MAG_W-1:0];
			neg3 = neg_s2;
		end else if (!neg_s2) begin
			mag3 = 11'(quo3) + F_OFFSET;
			neg3 = 1'b0;
		end else if (11'(quo3) > F_OFFSET) begin
			mag3 = 11'(quo3) - F_OFFSET;
			neg3 = 1'b1;
		end else begin
			mag3 = F_OFFSET - 11'(quo3);
			neg3 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			err_s1  <= reading > READING_LIMIT;
			fahr_s1 <= fahr;
			t_s1    <= t1;
		end
		if (rdy2) begin
			err_s2  <= err_s1;
			fahr_s2 <= fahr_s1;
			neg_s2  <= t_s1[11];
			val_s2  <= val2;
		end
		if (rdy3) begin
			err_s3  <= err_s2;
			fahr_s3 <= fahr_s2;
			neg_s3  <= neg3;
			mag_s3  <= mag3;
		end
	end

	assign out_valid     = v_s3;
	assign out_data.err  = err_s3;
	assign out_data.fahr = fahr_s3;
	assign out_data.neg  = neg_s3;
	assign out_data.mag  = mag_s3;

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !err_s3 |-> mag_s3 <= 11'd1220)
		else $error("converted magnitude out of range");

	a_neg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !err_s3 && neg_s3 |-> mag_s3 != '0)
		else $error("minus sign on zero");

	a_neg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !err_s3 && neg_s3 |-> mag_s3 <= 11'd580)
		else $error("negative magnitude too large");

endmodule

// ===== src/sst_digits.sv =====
// ----------------------------------------------------------------------------
// sst_digits: magnitude to seven-segment display word
// Three stages: ones digit, tens digit, hundreds and thousands plus encoding.
// The last stage is the output register.
// ----------------------------------------------------------------------------
module sst_digits (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  sst_pkg::conv_t            in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sst_pkg::WORD_W-1:0] word,
	output logic                      word_ok
);
	import sst_pkg::*;

	logic v_s4, v_s5, v_s6;
	logic rdy4, rdy5, rdy6;

	logic              err_s4, fahr_s4, neg_s4;
	logic [6:0]        q1_s4;
	logic [3:0]        d0_s4;
	logic              err_s5, fahr_s5, neg_s5;
	logic [3:0]        q2_s5, d1_s5, d0_s5;
	logic [WORD_W-1:0] word_s6;
	logic              ok_s6;

	logic [26:0]       prod4;
	logic [6:0]        q1;
	logic [MAG_W-1:0]  rem4;
	logic [14:0]       prod5;
	logic [3:0]        q2;
	logic [6:0]        rem5;
	logic              d3;
	logic [3:0]        d2;
	logic [WORD_W-1:0] word6;

	assign rdy6     = !v_s6 || out_ready;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign in_ready = rdy4;

	always_comb begin
		prod4 = 27'(in_data.mag) * 27'(RECIP10);
		q1    = prod4[25:19];
		rem4  = in_data.mag - 11'(q1) * 11'd10;
	end

	always_comb begin
		prod5 = 15'(q1_s4) * 15'(RECIP10_S);
		q2    = prod5[14:11];
		rem5  = q1_s4 - 7'(q2) * 7'd10;
	end

	// fill to two digits; the minus goes in the slot after the last digit
	always_comb begin
		d3    = q2_s5 >= 4'd10;
		d2    = d3 ? q2_s5 - 4'd10 : q2_s5;
		word6 = '0;
		word6[6:0]  = seg_digit(d0_s5);
		word6[13:7] = seg_digit(d1_s5);
		if (q2_s5 != '0) begin
			word6[20:14] = seg_digit(d2);
		end else if (neg_s5) begin
			word6[20:14] = MINUS_PAT;
		end
		if (d3) begin
			word6[27:21] = seg_digit(4'(d3));
		end else if (neg_s5 && q2_s5 != '0) begin
			word6[27:21] = MINUS_PAT;
		end
		word6[FAHRENHEIT_BIT] = fahr_s5;
		word6[CELSIUS_BIT]    = !fahr_s5;
		if (err_s5) begin
			word6 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy4) v_s4 <= in_valid;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			err_s4  <= in_data.err;
			fahr_s4 <= in_data.fahr;
			neg_s4  <= in_data.neg;
			q1_s4   <= q1;
			d0_s4   <= rem4[3:0];
		end
		if (rdy5) begin
			err_s5  <= err_s4;
			fahr_s5 <= fahr_s4;
			neg_s5  <= neg_s4;
			q2_s5   <= q2;
			d1_s5   <= rem5[3:0];
			d0_s5   <= d0_s4;
		end
		if (rdy6) begin
			word_s6 <= word6;
			ok_s6   <= !err_s5;
		end
	end

	assign out_valid = v_s6;
	assign word      = word_s6;
	assign word_ok   = ok_s6;

	a_unit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && ok_s6 |-> $onehot(word_s6[FAHRENHEIT_BIT:CELSIUS_BIT]))
		else $error("unit marks not one-hot");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !ok_s6 |-> word_s6 == '0)
		else $error("error word not cleared");

	a_two_digits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && ok_s6 |-> word_s6[13:7] != '0 && word_s6[6:0] != '0)
		else $error("fewer than two digits shown");

endmodule

// ===== src/sensor_to_seven_segment_temperature.sv =====
// ----------------------------------------------------------------------------
// sensor_to_seven_segment_temperature: thermometer display word generator
// Raw 16-bit sensor reading in, 30-bit seven-segment word out, in Celsius
// or Fahrenheit tenths of a degree.
// ----------------------------------------------------------------------------
// Channel        Direction  Payload
// s_axis         in         tdata[15:0] sensor_reading
// m_axis         out        tdata[29:0] display_word, tuser display_valid
// fahrenheit_*   in         one-bit unit register, written on _we
//
// Six register stages; one transaction per cycle while m_axis_tready stays high.
// The six stages are Celsius scaling, times nine, divide by five with the
// Fahrenheit offset, two divide-by-ten steps and the segment encoding.
// Reset clears the stage valid bits and selects Celsius.
// A stage holds while the stage after it is full and stalled; bubbles fill in,
// so input is taken while a finished result waits.
// ----------------------------------------------------------------------------
module sensor_to_seven_segment_temperature (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [15:0]                  s_axis_tdata,   // [15:0] sensor_reading
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [31:0]                  m_axis_tdata,   // [29:0] display_word, [31:30] zero
	output logic                         m_axis_tuser,   // [0] display_valid
	input  logic                         fahrenheit_mode_we,
	input  logic                         fahrenheit_mode_wdata
);
	import sst_pkg::*;

	logic              fahr_q;
	logic              mid_valid, mid_ready;
	conv_t             mid_data;
	logic [WORD_W-1:0] word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fahr_q <= 1'b0;
		end else if (fahrenheit_mode_we) begin
			fahr_q <= fahrenheit_mode_wdata;
		end
	end

	sst_convert u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.fahr      (fahr_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.reading   (s_axis_tdata),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	sst_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.word      (word),
		.word_ok   (m_axis_tuser)
	);

	assign m_axis_tdata = {2'b00, word};

endmodule
